// ===== rtl/core/rtpe_pkg.sv =====
// Package with the shared types, constants and handshake structs of the run-table pixel packer.
`default_nettype none

package rtpe_pkg;

  localparam int unsigned PACK_BYTES_DEF  = 8;
  localparam int unsigned TABLE_DEPTH_DEF = 512;
  localparam int unsigned MAX_GROUPS      = 17;
  localparam int unsigned ADDR_W          = 9;
  localparam int unsigned DATA_W          = 8;
  localparam int unsigned PIX_W           = 4;
  localparam int unsigned GROUP_BYTES     = 8;
  localparam int unsigned COUNT_W         = 4;
  localparam int unsigned REM_W           = 8;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_EXPAND = 2'd1,
    OP_PIXEL  = 2'd2,
    OP_FLUSH  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] table_address;
    logic [DATA_W-1:0] table_data;
    logic [ADDR_W-1:0] sequence_id;
    logic [PIX_W-1:0]  pixel_value;
  } in_req_t;

  typedef struct packed {
    logic [GROUP_BYTES*8-1:0] group_bytes;
    logic [COUNT_W-1:0]       byte_count;
    logic                     last;
  } out_rsp_t;

  typedef struct packed {
    logic accept;
    logic rd_next;
    logic cap_cnt;
    logic cap_val;
    logic step;
    logic flush;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic cnt_zero;
    logic run_done;
  } ctl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/run_table_pixel_expander_packer_core.sv =====
// A load is written to the run table when accepted; a single pixel takes one packer step and a
// flush emits the held partial group, if any; an expand reads count and value from the table,
// then takes one packer step per group, ceil((held + count) / (2*PACK_BYTES)). One request
// at a time; each step fills up to one whole group and waits while a stalled result is held.
// Reset clears the controller, the packing position and the output valid; the run table
// and the pack store are undefined until written.
`default_nettype none

module run_table_pixel_expander_packer_core
  import rtpe_pkg::*;
#(
  parameter int unsigned PACK_BYTES  = PACK_BYTES_DEF,
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire in_req_t in_req_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output out_rsp_t     out_rsp_o
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  rtpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (op_e'(in_req_i.operation)),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rtpe_datapath #(
    .PACK_BYTES  (PACK_BYTES),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/rtpe_ctrl.sv =====
// Controller state machine that sequences table reads, run steps and flushes.
`default_nettype none

module rtpe_ctrl
  import rtpe_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire op_e      in_op_i,
  output logic          in_stall_o,
  input  wire ctl_sts_t sts_i,
  output ctl_cmd_t      cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_RD_CNT  = 6'b000010,
    ST_RD_VAL  = 6'b000100,
    ST_GET_VAL = 6'b001000,
    ST_RUN     = 6'b010000,
    ST_FLUSH   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (in_op_i)
            OP_EXPAND: state_d = ST_RD_CNT;
            OP_PIXEL:  state_d = ST_RUN;
            OP_FLUSH:  state_d = ST_FLUSH;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_RD_CNT: begin
        state_d = ST_RD_VAL;
      end
      ST_RD_VAL: begin
        cmd_o.rd_next = 1'b1;
        cmd_o.cap_cnt = 1'b1;
        state_d       = ST_GET_VAL;
      end
      ST_GET_VAL: begin
        cmd_o.cap_val = 1'b1;
        state_d       = sts_i.cnt_zero ? ST_IDLE : ST_RUN;
      end
      ST_RUN: begin
        if (sts_i.out_free) begin
          cmd_o.step = 1'b1;
          if (sts_i.run_done) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/rtpe_datapath.sv =====
// Datapath with the run table memory, the nibble packer and the output register.
`default_nettype none

module rtpe_datapath
  import rtpe_pkg::*;
#(
  parameter int unsigned PACK_BYTES  = PACK_BYTES_DEF,
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire in_req_t  in_req_i,
  input  wire ctl_cmd_t cmd_i,
  output ctl_sts_t      sts_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_rsp_t      out_rsp_o
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned NIB_W = $clog2(2 * PACK_BYTES + 1);
  localparam int unsigned CUR_W = NIB_W - 1;
  localparam int unsigned GRP_W = $clog2(MAX_GROUPS + 1);
  localparam logic [NIB_W-1:0] NIB_FULL = NIB_W'(2 * PACK_BYTES);
  localparam logic [GRP_W-1:0] GRP_MAX  = GRP_W'(MAX_GROUPS);
  localparam logic [GRP_W-1:0] GRP_END  = GRP_W'(MAX_GROUPS - 1);

  function automatic logic [IDX_W-1:0] tbl_index(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] r;
    r = a;
    for (int k = ADDR_W - 1; k >= 0; k--) begin
      if ((TABLE_DEPTH << k) <= int'(r)) begin
        r = ADDR_W'(int'(r) - (TABLE_DEPTH << k));
      end
    end
    return IDX_W'(r);
  endfunction

  logic [DATA_W-1:0] mem [TABLE_DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [IDX_W-1:0]  raddr;
  logic [IDX_W:0]    idx_sum;
  logic [IDX_W-1:0]  idx_inc;
  logic              mem_we;

  logic [IDX_W-1:0]  idx_q;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [PIX_W-1:0]  val_q;
  logic [NIB_W-1:0]  pos_q, pos_d;
  logic [GRP_W-1:0]  grp_q, grp_d;
  logic [7:0]        store_q [PACK_BYTES];
  logic [7:0]        store_d [PACK_BYTES];

  logic [NIB_W-1:0]  space;
  logic [NIB_W-1:0]  n_pix;
  logic [NIB_W-1:0]  pos_end;
  logic [REM_W-1:0]  rem_nx;
  logic              full;
  logic              emit_step;
  logic              emit_flush;
  logic              step_last;
  logic [CUR_W-1:0]  cursor;

  logic              out_valid_q;
  out_rsp_t          out_q, out_d;
  logic [COUNT_W-1:0] count_sel;
  logic [7:0]        byte_sel [GROUP_BYTES];

  assign idx_sum = {1'b0, idx_q} + {{IDX_W{1'b0}}, 1'b1};
  assign idx_inc = (idx_sum == (IDX_W + 1)'(TABLE_DEPTH)) ? '0 : idx_sum[IDX_W-1:0];
  assign raddr   = cmd_i.rd_next ? idx_inc : idx_q;
  assign mem_we  = cmd_i.accept && (op_e'(in_req_i.operation) == OP_LOAD);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tbl_index(in_req_i.table_address)] <= in_req_i.table_data;
    end
    rdata_q <= mem[raddr];
  end

  assign cursor = pos_q[NIB_W-1:1];
  assign space  = NIB_FULL - pos_q;
  assign n_pix  = (rem_q < REM_W'(space)) ? NIB_W'(rem_q) : space;
  assign pos_end = pos_q + n_pix;
  assign rem_nx  = rem_q - REM_W'(n_pix);
  assign full    = (pos_end == NIB_FULL);
  assign emit_step  = cmd_i.step && full && (grp_q < GRP_MAX);
  assign emit_flush = cmd_i.flush && (cursor != '0);
  assign step_last  = (rem_nx < REM_W'(NIB_FULL)) || (grp_q == GRP_END);

  always_comb begin
    logic [NIB_W-1:0] hi_pos;
    logic [NIB_W-1:0] lo_pos;
    logic             hi_w;
    logic             lo_w;
    for (int i = 0; i < PACK_BYTES; i++) begin
      hi_pos = NIB_W'(2 * i);
      lo_pos = NIB_W'(2 * i + 1);
      hi_w   = cmd_i.step && (pos_q <= hi_pos) && (hi_pos < pos_end);
      lo_w   = cmd_i.step && (pos_q <= lo_pos) && (lo_pos < pos_end);
      store_d[i] = store_q[i];
      if (hi_w) begin
        store_d[i][7:4] = val_q;
        store_d[i][3:0] = '0;
      end
      if (lo_w) begin
        store_d[i][3:0] = val_q;
      end
    end
  end

  always_comb begin
    pos_d = pos_q;
    rem_d = rem_q;
    grp_d = grp_q;
    if (cmd_i.accept) begin
      rem_d = REM_W'(1);
      grp_d = '0;
    end else if (cmd_i.cap_cnt) begin
      rem_d = rdata_q;
    end else if (cmd_i.step) begin
      rem_d = rem_nx;
      pos_d = full ? '0 : pos_end;
      if (full && (grp_q < GRP_MAX)) begin
        grp_d = grp_q + GRP_W'(1);
      end
    end else if (cmd_i.flush) begin
      pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      rem_q       <= '0;
      grp_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      rem_q <= rem_d;
      grp_q <= grp_d;
      if (emit_step || emit_flush) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q <= tbl_index(in_req_i.sequence_id);
      val_q <= in_req_i.pixel_value;
    end else if (cmd_i.cap_val) begin
      val_q <= rdata_q[PIX_W-1:0];
    end
    for (int i = 0; i < PACK_BYTES; i++) begin
      store_q[i] <= store_d[i];
    end
    if (emit_step || emit_flush) begin
      out_q <= out_d;
    end
  end

  assign count_sel = cmd_i.step ? COUNT_W'(PACK_BYTES) : COUNT_W'(cursor);

  for (genvar g = 0; g < GROUP_BYTES; g++) begin : g_byte
    if (g < PACK_BYTES) begin : g_used
      assign byte_sel[g] = (COUNT_W'(g) < count_sel) ? store_d[g] : 8'h00;
    end else begin : g_unused
      assign byte_sel[g] = 8'h00;
    end
    assign out_d.group_bytes[8*g +: 8] = byte_sel[g];
  end

  assign out_d.byte_count = count_sel;
  assign out_d.last       = cmd_i.step ? step_last : 1'b1;

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign sts_o.cnt_zero = (rem_q == '0);
  assign sts_o.run_done = (rem_nx == '0);

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/rtpe_checker.sv =====
// Port-level checker for the run-table pixel packer and its bind to the top level.
`default_nettype none

module rtpe_checker
  import rtpe_pkg::*;
#(
  parameter int unsigned PACK_BYTES = PACK_BYTES_DEF
) (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire in_req_t  in_req_i,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire out_rsp_t out_rsp_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed or dropped");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.byte_count != '0) &&
                    (out_rsp_o.byte_count <= COUNT_W'(PACK_BYTES)))
    else $error("byte count out of range");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.byte_count < COUNT_W'(GROUP_BYTES)) |->
      ((out_rsp_o.group_bytes >> {out_rsp_o.byte_count, 3'b000}) == '0))
    else $error("bytes above the count are not zero");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request in progress");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_e'(in_req_i.operation) != OP_LOAD) |=> in_stall_o)
    else $error("request did not occupy the block");

endmodule

bind run_table_pixel_expander_packer_core rtpe_checker #(
  .PACK_BYTES (PACK_BYTES)
) u_rtpe_checker (.*);

`default_nettype wire

// ===== dv/run_table_pixel_expander_packer_core_tb.sv =====
// Self-checking testbench that drives table loads, run expands, single pixels and flushes.
`timescale 1ns / 100ps

module run_table_pixel_expander_packer_core_tb;
  import rtpe_pkg::*;

  localparam int unsigned TBL_DEPTH        = TABLE_DEPTH_DEF;
  localparam int unsigned MAX_ID           = TABLE_DEPTH_DEF - 2;
  localparam int unsigned DRAIN_CYCLES     = 40;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned ITEMS_PER_PHASE  = 65;

  typedef struct {
    in_req_t  req;
    bit       typed;
    int       n_typed;
    out_rsp_t rsp;
  } script_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  in_req_t  in_req_i;
  logic     out_valid_o;
  logic     out_stall_i;
  out_rsp_t out_rsp_o;

  logic [7:0]  run_tbl [TBL_DEPTH];
  bit          tbl_loaded [TBL_DEPTH];
  logic [7:0]  pack_bytes [PACK_BYTES_DEF];
  int          byte_pos;
  bit          nibble_waiting;
  int          ready_ids [$];
  out_rsp_t    fresh_groups [$];
  out_rsp_t    awaited_groups [$];
  script_row_t script [$];

  int fail_count    = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit long_hold     = 1'b0;
  int items_left    = 0;

  run_table_pixel_expander_packer_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic close_group();
    logic [63:0] merged;
    out_rsp_t    grp;
    merged = '0;
    for (int i = 0; i < byte_pos; i++) merged[8*i +: 8] = pack_bytes[i];
    if (fresh_groups.size() < MAX_GROUPS) begin
      grp.group_bytes = merged;
      grp.byte_count  = COUNT_W'(byte_pos);
      grp.last        = 1'b0;
      fresh_groups.push_back(grp);
    end
    byte_pos       = 0;
    nibble_waiting = 1'b0;
  endtask

  task automatic push_pixel(input logic [3:0] level);
    if (nibble_waiting) begin
      pack_bytes[byte_pos] = {pack_bytes[byte_pos][7:4], level};
      nibble_waiting = 1'b0;
      byte_pos++;
    end else begin
      pack_bytes[byte_pos] = {level, 4'h0};
      nibble_waiting = 1'b1;
    end
    if (byte_pos >= PACK_BYTES_DEF) close_group();
  endtask

  task automatic predict_groups(input in_req_t r);
    logic [7:0] count;
    logic [7:0] level_byte;
    out_rsp_t   grp;
    fresh_groups.delete();
    case (op_e'(r.operation))
      OP_LOAD: begin
        run_tbl[r.table_address]    = r.table_data;
        tbl_loaded[r.table_address] = 1'b1;
        if (r.table_address > 0 && tbl_loaded[r.table_address - 1])
          ready_ids.push_back(r.table_address - 1);
        if (r.table_address <= MAX_ID && tbl_loaded[r.table_address + 1])
          ready_ids.push_back(r.table_address);
      end
      OP_EXPAND: begin
        count      = run_tbl[r.sequence_id];
        level_byte = run_tbl[(r.sequence_id + 1) % TBL_DEPTH];
        for (int i = 0; i < count; i++) push_pixel(level_byte[3:0]);
      end
      OP_PIXEL: begin
        push_pixel(r.pixel_value);
      end
      OP_FLUSH: begin
        if (byte_pos > 0) close_group();
        byte_pos       = 0;
        nibble_waiting = 1'b0;
      end
    endcase
    if (fresh_groups.size() > 0) begin
      grp      = fresh_groups.pop_back();
      grp.last = 1'b1;
      fresh_groups.push_back(grp);
    end
  endtask

  task automatic send_request(input in_req_t r, input bit typed, input int n_typed,
                              input out_rsp_t typed_rsp);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_req_i   = r;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    predict_groups(r);
    if (typed) begin
      if (n_typed > 0) awaited_groups.push_back(typed_rsp);
    end else begin
      foreach (fresh_groups[i]) awaited_groups.push_back(fresh_groups[i]);
    end
    items_left--;
  endtask

  task automatic add_row(input op_e op, input int addr, input int data, input int id,
                         input int pix, input bit typed, input int n_typed,
                         input logic [63:0] grp_bytes, input int cnt);
    script_row_t row;
    row.req.operation     = op;
    row.req.table_address = ADDR_W'(addr);
    row.req.table_data    = DATA_W'(data);
    row.req.sequence_id   = ADDR_W'(id);
    row.req.pixel_value   = PIX_W'(pix);
    row.typed             = typed;
    row.n_typed           = n_typed;
    row.rsp.group_bytes   = grp_bytes;
    row.rsp.byte_count    = COUNT_W'(cnt);
    row.rsp.last          = 1'b1;
    script.push_back(row);
  endtask

  function automatic in_req_t noise_req(input op_e op);
    in_req_t r;
    r.operation     = op;
    r.table_address = ADDR_W'($urandom_range(TBL_DEPTH - 1));
    r.table_data    = DATA_W'($urandom_range(255));
    r.sequence_id   = ADDR_W'($urandom_range(MAX_ID));
    r.pixel_value   = PIX_W'($urandom_range(15));
    return r;
  endfunction

  task automatic random_phase(input int idle_pct, input int hold_pct, input int n);
    in_req_t  r;
    out_rsp_t none;
    int       pick;
    int       base;
    none          = '0;
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    items_left    = n;
    while (items_left > 0) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        base            = $urandom_range(MAX_ID);
        r               = noise_req(OP_LOAD);
        r.table_address = ADDR_W'(base);
        r.table_data    = ($urandom_range(3) == 0) ? DATA_W'($urandom_range(255))
                                                   : DATA_W'($urandom_range(40));
        send_request(r, 1'b0, 0, none);
        r               = noise_req(OP_LOAD);
        r.table_address = ADDR_W'(base + 1);
        send_request(r, 1'b0, 0, none);
        r               = noise_req(OP_EXPAND);
        r.sequence_id   = ADDR_W'(base);
        send_request(r, 1'b0, 0, none);
      end else if (pick < 50 && ready_ids.size() > 0) begin
        r             = noise_req(OP_EXPAND);
        r.sequence_id = ADDR_W'(ready_ids[$urandom_range(ready_ids.size() - 1)]);
        send_request(r, 1'b0, 0, none);
      end else if (pick < 82) begin
        send_request(noise_req(OP_PIXEL), 1'b0, 0, none);
      end else if (pick < 90) begin
        send_request(noise_req(OP_LOAD), 1'b0, 0, none);
      end else begin
        send_request(noise_req(OP_FLUSH), 1'b0, 0, none);
      end
    end
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_stall_i = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk_i);
        long_hold = 1'b0;
      end
      out_stall_i = ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : group_check
    out_rsp_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (awaited_groups.size() == 0) begin
        $error("unexpected group: group_bytes %h byte_count %0d last %0b",
               out_rsp_o.group_bytes, out_rsp_o.byte_count, out_rsp_o.last);
        fail_count++;
      end else begin
        want = awaited_groups.pop_front();
        if (out_rsp_o.group_bytes !== want.group_bytes) begin
          $error("group_bytes: expected %h, actual %h", want.group_bytes,
                 out_rsp_o.group_bytes);
          fail_count++;
        end
        if (out_rsp_o.byte_count !== want.byte_count) begin
          $error("byte_count: expected %0d, actual %0d", want.byte_count,
                 out_rsp_o.byte_count);
          fail_count++;
        end
        if (out_rsp_o.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_rsp_o.last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_req_i       = '0;
    byte_pos       = 0;
    nibble_waiting = 1'b0;

    add_row(OP_FLUSH,    0,     0,   0,   0, 1'b1, 0, 64'h0,  0);
    add_row(OP_LOAD,     0, 8'h03,   0,   0, 1'b1, 0, 64'h0,  0);
    add_row(OP_LOAD,     1, 8'hFA,   0,   0, 1'b1, 0, 64'h0,  0);
    add_row(OP_LOAD,     2, 8'h00,   0,   0, 1'b1, 0, 64'h0,  0);
    add_row(OP_LOAD,     3, 8'h05,   0,   0, 1'b1, 0, 64'h0,  0);
    add_row(OP_LOAD,   510, 8'hFF,   0,   0, 1'b1, 0, 64'h0,  0);
    add_row(OP_LOAD,   511, 8'hF7,   0,   0, 1'b1, 0, 64'h0,  0);
    add_row(OP_LOAD,   256, 8'h10,   0,   0, 1'b1, 0, 64'h0,  0);
    add_row(OP_LOAD,   257, 8'hF0,   0,   0, 1'b1, 0, 64'h0,  0);
    add_row(OP_PIXEL,    0,     0,   0,  15, 1'b1, 0, 64'h0,  0);
    add_row(OP_PIXEL,    0,     0,   0,   0, 1'b1, 0, 64'h0,  0);
    add_row(OP_FLUSH,    0,     0,   0,   0, 1'b1, 1, 64'hF0, 1);
    add_row(OP_EXPAND,   0,     0, 256,   0, 1'b1, 1, 64'h0,  8);
    add_row(OP_EXPAND,   0,     0,   2,   0, 1'b1, 0, 64'h0,  0);
    add_row(OP_PIXEL,    0,     0,   0,   5, 1'b1, 0, 64'h0,  0);
    add_row(OP_FLUSH,    0,     0,   0,   0, 1'b1, 0, 64'h0,  0);
    add_row(OP_EXPAND,   0,     0,   0,   0, 1'b1, 0, 64'h0,  0);
    add_row(OP_FLUSH,    0,     0,   0,   0, 1'b1, 1, 64'hAA, 1);
    add_row(OP_EXPAND,   0,     0, 510,   0, 1'b0, 0, 64'h0,  0);
    add_row(OP_FLUSH,    0,     0,   0,   0, 1'b0, 0, 64'h0,  0);
    add_row(OP_PIXEL,    0,     0,   0,  15, 1'b1, 0, 64'h0,  0);
    add_row(OP_EXPAND,   0,     0, 510,   0, 1'b0, 0, 64'h0,  0);
    add_row(OP_FLUSH,    0,     0,   0,   0, 1'b0, 0, 64'h0,  0);

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (script[i])
      send_request(script[i].req, script[i].typed, script[i].n_typed, script[i].rsp);

    long_hold = 1'b1;
    random_phase(0, 0, ITEMS_PER_PHASE);
    random_phase(78, 0, ITEMS_PER_PHASE);
    random_phase(0, 78, ITEMS_PER_PHASE);
    random_phase(27, 27, ITEMS_PER_PHASE);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (awaited_groups.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
